### sv/mcstb_pkg.sv
`timescale 1ns / 1ps

package mcstb_pkg;

   // Function codes of an input item
   localparam logic [2:0] FUNC_TICK       = 3'd0;
   localparam logic [2:0] FUNC_DECLARE    = 3'd1;
   localparam logic [2:0] FUNC_START      = 3'd2;
   localparam logic [2:0] FUNC_CANCEL     = 3'd3;
   localparam logic [2:0] FUNC_CLEAR      = 3'd4;
   localparam logic [2:0] FUNC_SET_PERIOD = 3'd5;
   localparam logic [2:0] FUNC_STATUS     = 3'd6;
   localparam logic [2:0] FUNC_READ_MS    = 3'd7;

   // Timer modes
   localparam logic [1:0] MODE_CALLBACK = 2'd0;
   localparam logic [1:0] MODE_ELAPSED  = 2'd1;
   localparam logic [1:0] MODE_EVENT    = 2'd2;
   localparam logic [1:0] MODE_DUAL     = 2'd3;

   // Status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // Most fired timers reported for one tick
   localparam int MAX_REPORTS = 8;
   localparam int REP_W       = 4;

   typedef struct packed {
      logic [2:0]  func;
      logic [2:0]  timer_id;
      logic [15:0] period;
      logic        repeating;
      logic [1:0]  mode;
      logic [7:0]  event_code;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  slot;
      logic        fired_callback;
      logic        fired_event;
      logic [7:0]  event_out;
      logic        elapsed_flag;
      logic        active_flag;
      logic        status;
      logic [31:0] ms_count;
      logic        last;
   } rsp_item_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic exec_op;
      logic scan_step;
      logic flush;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic is_tick;
      logic started;
      logic cur_used;
      logic at_last;
   } sts_type;

endpackage

### sv/mcstb_ctrl.sv
`timescale 1ns / 1ps

module mcstb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  mcstb_pkg::sts_type sts,
   output mcstb_pkg::cmd_type cmd
);
   import mcstb_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EXEC  = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign busy = (state_ff != ST_IDLE);

   // Sequence one item: execute, then walk the slots for a started tick
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec_op = 1'b1;
            if (sts.is_tick && sts.started) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (!sts.cur_used || sts.at_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_capture_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == ST_EXEC))
      else $error("capture did not lead to execute");
   a_scan_from_tick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) && !(sts.is_tick && sts.started) |=> (state_ff == ST_IDLE))
      else $error("non-tick item went on past execute");
   a_flush_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |=> !busy)
      else $error("flush did not return to idle");

endmodule

### sv/mcstb_dp.sv
`timescale 1ns / 1ps

module mcstb_dp #(
   parameter int NUM_TIMERS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mcstb_pkg::req_item_type req_item,
   input  mcstb_pkg::cmd_type      cmd,
   output mcstb_pkg::sts_type      sts,
   output logic                    rsp_strobe,
   output mcstb_pkg::rsp_item_type rsp_item
);
   import mcstb_pkg::*;

   localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   // Request latch and bank-wide state
   req_item_type req_ff, req_in;
   logic [31:0]  global_ff, global_in;
   logic         started_ff, started_in;

   // Per-slot flags
   logic [NUM_TIMERS-1:0] used_ff, used_in;
   logic [NUM_TIMERS-1:0] active_ff, active_in;
   logic [NUM_TIMERS-1:0] elapsed_ff, elapsed_in;

   // Per-slot payload, written at one address a cycle
   logic [31:0] count_ff  [NUM_TIMERS];
   logic [15:0] period_ff [NUM_TIMERS];
   logic        repeat_ff [NUM_TIMERS];
   logic [1:0]  mode_ff   [NUM_TIMERS];
   logic [7:0]  event_ff  [NUM_TIMERS];

   logic [IW-1:0] wr_idx;
   logic          count_we, period_we, decl_we;
   logic [31:0]   count_wd;
   logic [15:0]   period_wd;

   // Scan state and the held fired item
   logic [IW-1:0]    scan_idx_ff, scan_idx_in;
   logic [REP_W-1:0] rep_cnt_ff, rep_cnt_in;
   logic             pend_valid_ff, pend_valid_in;
   rsp_item_type     pend_ff, pend_in;

   // Output register
   logic         rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type rsp_ff, rsp_in;

   // Helpers
   logic [IW-1:0] id_idx;
   logic          id_ok;
   logic [IW-1:0] free_idx;
   logic          full;
   logic [31:0]   cnt_inc;
   logic          fire;
   logic [1:0]    cur_mode;
   logic          fire_cb, fire_ev, fire_el;
   rsp_item_type  fire_item;

   assign id_idx = IW'(req_ff.timer_id);
   assign id_ok  = (32'(req_ff.timer_id) < NUM_TIMERS) && used_ff[id_idx];
   assign full   = &used_ff;

   // Find the lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_idx = IW'(i);
         end
      end
   end

   // Bump and compare the scanned slot
   assign cnt_inc  = count_ff[scan_idx_ff] + 32'd1;
   assign fire     = active_ff[scan_idx_ff] && (cnt_inc == {16'd0, period_ff[scan_idx_ff]});
   assign cur_mode = mode_ff[scan_idx_ff];
   assign fire_cb  = (cur_mode == MODE_CALLBACK) || (cur_mode == MODE_DUAL);
   assign fire_ev  = (cur_mode == MODE_EVENT) || (cur_mode == MODE_DUAL);
   assign fire_el  = elapsed_ff[scan_idx_ff] || (cur_mode == MODE_ELAPSED);

   always_comb begin
      fire_item                = '0;
      fire_item.slot           = 3'(scan_idx_ff);
      fire_item.fired_callback = fire_cb;
      fire_item.fired_event    = fire_ev;
      fire_item.event_out      = fire_ev ? event_ff[scan_idx_ff] : 8'd0;
      fire_item.elapsed_flag   = fire_el;
      fire_item.active_flag    = repeat_ff[scan_idx_ff];
   end

   // Next-state logic for all commands
   always_comb begin
      req_in        = req_ff;
      global_in     = global_ff;
      started_in    = started_ff;
      used_in       = used_ff;
      active_in     = active_ff;
      elapsed_in    = elapsed_ff;
      scan_idx_in   = scan_idx_ff;
      rep_cnt_in    = rep_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_idx        = scan_idx_ff;
      count_we      = 1'b0;
      count_wd      = '0;
      period_we     = 1'b0;
      period_wd     = req_ff.period;
      decl_we       = 1'b0;

      if (cmd.capture) begin
         req_in = req_item;
      end

      if (cmd.exec_op) begin
         rsp_in      = '0;
         rsp_in.last = 1'b1;
         rsp_in.slot = req_ff.timer_id;
         unique case (req_ff.func)
            FUNC_TICK: begin
               if (started_ff) begin
                  global_in     = global_ff + 32'd1;
                  scan_idx_in   = '0;
                  rep_cnt_in    = '0;
                  pend_valid_in = 1'b0;
               end
            end
            FUNC_DECLARE: begin
               if (full) begin
                  rsp_in.slot   = 3'd0;
                  rsp_in.status = STATUS_FULL;
               end else begin
                  rsp_in.slot          = 3'(free_idx);
                  used_in[free_idx]    = 1'b1;
                  active_in[free_idx]  = 1'b0;
                  elapsed_in[free_idx] = 1'b0;
                  wr_idx               = free_idx;
                  count_we             = 1'b1;
                  period_we            = 1'b1;
                  decl_we              = 1'b1;
               end
            end
            FUNC_START: begin
               started_in = 1'b1;
               if (id_ok) begin
                  active_in[id_idx] = 1'b1;
               end
            end
            FUNC_CANCEL: begin
               if (id_ok) begin
                  active_in[id_idx] = 1'b0;
                  wr_idx            = id_idx;
                  count_we          = 1'b1;
               end
            end
            FUNC_CLEAR: begin
               if (id_ok) begin
                  elapsed_in[id_idx] = 1'b0;
               end
            end
            FUNC_SET_PERIOD: begin
               if (id_ok) begin
                  wr_idx    = id_idx;
                  period_we = 1'b1;
               end
            end
            FUNC_STATUS: begin
               if (id_ok) begin
                  rsp_in.elapsed_flag = elapsed_ff[id_idx];
                  rsp_in.active_flag  = active_ff[id_idx];
               end
            end
            FUNC_READ_MS: begin
               rsp_in.slot     = 3'd0;
               rsp_in.ms_count = global_ff;
            end
            default: rsp_in.slot = 3'd0;
         endcase
         rsp_strobe_in = (req_ff.func != FUNC_TICK);
      end

      // Advance one slot; a new firing releases the held item
      if (cmd.scan_step) begin
         scan_idx_in = scan_idx_ff + IW'(1);
         if (used_ff[scan_idx_ff] && active_ff[scan_idx_ff]) begin
            count_we = 1'b1;
            count_wd = fire ? 32'd0 : cnt_inc;
            if (fire) begin
               active_in[scan_idx_ff]  = repeat_ff[scan_idx_ff];
               elapsed_in[scan_idx_ff] = fire_el;
               if (rep_cnt_ff < REP_W'(MAX_REPORTS)) begin
                  if (pend_valid_ff) begin
                     rsp_in        = pend_ff;
                     rsp_strobe_in = 1'b1;
                  end
                  pend_in       = fire_item;
                  pend_valid_in = 1'b1;
                  rep_cnt_in    = rep_cnt_ff + REP_W'(1);
               end
            end
         end
      end

      // Drop the held item out as the last of the tick
      if (cmd.flush) begin
         if (pend_valid_ff) begin
            rsp_in        = pend_ff;
            rsp_in.last   = 1'b1;
            rsp_strobe_in = 1'b1;
         end
         pend_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         global_ff     <= '0;
         started_ff    <= 1'b0;
         used_ff       <= '0;
         active_ff     <= '0;
         elapsed_ff    <= '0;
         rep_cnt_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         global_ff     <= global_in;
         started_ff    <= started_in;
         used_ff       <= used_in;
         active_ff     <= active_in;
         elapsed_ff    <= elapsed_in;
         rep_cnt_ff    <= rep_cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      scan_idx_ff <= scan_idx_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      if (count_we) begin
         count_ff[wr_idx] <= count_wd;
      end
      if (period_we) begin
         period_ff[wr_idx] <= period_wd;
      end
      if (decl_we) begin
         repeat_ff[wr_idx] <= req_ff.repeating;
         mode_ff[wr_idx]   <= req_ff.mode;
         event_ff[wr_idx]  <= req_ff.event_code;
      end
   end

   assign sts.is_tick  = (req_ff.func == FUNC_TICK);
   assign sts.started  = started_ff;
   assign sts.cur_used = used_ff[scan_idx_ff];
   assign sts.at_last  = (scan_idx_ff == IW'(NUM_TIMERS - 1));

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   a_rep_bound: assert property (@(posedge clock) disable iff (reset)
      rep_cnt_ff <= REP_W'(MAX_REPORTS))
      else $error("fired report count overran");
   a_active_used: assert property (@(posedge clock) disable iff (reset)
      (active_ff & ~used_ff) == '0)
      else $error("active timer in an undeclared slot");
   a_used_prefix: assert property (@(posedge clock) disable iff (reset)
      $onehot({1'b0, used_ff} + (NUM_TIMERS + 1)'(1)))
      else $error("declared slots are not a prefix");
   a_ms_before_start: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> (global_ff == 32'd0))
      else $error("millisecond count moved before start");

endmodule

### sv/multi_channel_soft_timer_bank.sv
`timescale 1ns / 1ps

// Bank of NUM_TIMERS millisecond soft timers, one item at a time. An item is
// taken when start is high and busy low; every function but tick answers with
// one result, registered after the execute state, and holds busy through that
// state only, so the next item can be taken once it has run. A tick walks the
// declared slots one per cycle through a single 32-bit increment and compare,
// holding busy through execute, the slot walk and flush. It emits one result
// per fired timer (at most eight, last marked), none if nothing fired or no
// start was seen yet; the last result comes out in the cycle in which busy
// drops. Results appear on rsp_item for one cycle with rsp_strobe high; the
// receiver cannot stall them.
module multi_channel_soft_timer_bank #(
   parameter int NUM_TIMERS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  mcstb_pkg::req_item_type req_item,
   output logic                    rsp_strobe,
   output mcstb_pkg::rsp_item_type rsp_item
);
   import mcstb_pkg::*;

   cmd_type cmd;
   sts_type sts;

   mcstb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   mcstb_dp #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

### test/timer_bank_checker.sv
`timescale 1ns / 1ps

// Watch both channels of the timer bank, keep a shadow copy of the timer table,
// work out the results due for every accepted item and compare them in order.
module timer_bank_checker #(
   parameter int NUM_TIMERS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  mcstb_pkg::req_item_type req_item,
   input  logic                    rsp_strobe,
   input  mcstb_pkg::rsp_item_type rsp_item,
   output int                      error_count,
   output int                      results_due
);
   import mcstb_pkg::*;

   // Shadow timer table
   logic        declared     [NUM_TIMERS];
   logic        running      [NUM_TIMERS];
   logic        repeats      [NUM_TIMERS];
   logic [1:0]  timer_mode   [NUM_TIMERS];
   logic [15:0] timer_period [NUM_TIMERS];
   logic [7:0]  timer_event  [NUM_TIMERS];
   logic        elapsed      [NUM_TIMERS];
   logic [31:0] tick_count   [NUM_TIMERS];
   logic [31:0] ms_total;
   logic        bank_started;

   // Results still owed by the block, oldest first
   rsp_item_type owed_results[$];

   initial begin
      error_count = 0;
      results_due = 0;
   end

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      error_count++;
   endtask

   task automatic compare_field(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         flag_mismatch(what, got, want);
   endtask

   task automatic clear_bank();
      for (int i = 0; i < NUM_TIMERS; i++) begin
         declared[i]     = 1'b0;
         running[i]      = 1'b0;
         repeats[i]      = 1'b0;
         timer_mode[i]   = MODE_CALLBACK;
         timer_period[i] = '0;
         timer_event[i]  = '0;
         elapsed[i]      = 1'b0;
         tick_count[i]   = '0;
      end
      ms_total     = '0;
      bank_started = 1'b0;
   endtask

   // Advance the shadow table by one item and queue the results it causes
   task automatic predict_item(input req_item_type it);
      rsp_item_type r;
      rsp_item_type fired[$];
      int           k;
      int           free_slot;
      logic         hit;
      logic         cb;
      logic         ev;
      r      = '0;
      r.last = 1'b1;
      k      = it.timer_id;
      hit    = (k < NUM_TIMERS) && declared[k];
      case (it.func)
         FUNC_TICK: begin
            if (bank_started) begin
               ms_total = ms_total + 32'd1;
               // Walk the declared prefix of the table
               for (int i = 0; i < NUM_TIMERS; i++) begin
                  if (!declared[i])
                     break;
                  if (running[i]) begin
                     tick_count[i] = tick_count[i] + 32'd1;
                     if (tick_count[i] == 32'(timer_period[i])) begin
                        cb = (timer_mode[i] == MODE_CALLBACK) || (timer_mode[i] == MODE_DUAL);
                        ev = (timer_mode[i] == MODE_EVENT) || (timer_mode[i] == MODE_DUAL);
                        running[i]    = repeats[i];
                        tick_count[i] = '0;
                        if (timer_mode[i] == MODE_ELAPSED)
                           elapsed[i] = 1'b1;
                        if (fired.size() < MAX_REPORTS) begin
                           r                = '0;
                           r.slot           = 3'(i);
                           r.fired_callback = cb;
                           r.fired_event    = ev;
                           r.event_out      = ev ? timer_event[i] : 8'd0;
                           r.elapsed_flag   = elapsed[i];
                           r.active_flag    = running[i];
                           fired.push_back(r);
                        end
                     end
                  end
               end
            end
            // Mark the final report of this tick
            foreach (fired[j]) begin
               r      = fired[j];
               r.last = (j == fired.size() - 1);
               owed_results.push_back(r);
            end
         end
         FUNC_DECLARE: begin
            free_slot = NUM_TIMERS;
            for (int i = NUM_TIMERS - 1; i >= 0; i--)
               if (!declared[i])
                  free_slot = i;
            if (free_slot == NUM_TIMERS) begin
               r.status = STATUS_FULL;
            end else begin
               declared[free_slot]     = 1'b1;
               running[free_slot]      = 1'b0;
               tick_count[free_slot]   = '0;
               elapsed[free_slot]      = 1'b0;
               timer_period[free_slot] = it.period;
               repeats[free_slot]      = it.repeating;
               timer_mode[free_slot]   = it.mode;
               timer_event[free_slot]  = it.event_code;
               r.slot                  = 3'(free_slot);
            end
            owed_results.push_back(r);
         end
         FUNC_START: begin
            bank_started = 1'b1;
            if (hit)
               running[k] = 1'b1;
            r.slot = it.timer_id;
            owed_results.push_back(r);
         end
         FUNC_CANCEL: begin
            if (hit) begin
               running[k]    = 1'b0;
               tick_count[k] = '0;
            end
            r.slot = it.timer_id;
            owed_results.push_back(r);
         end
         FUNC_CLEAR: begin
            if (hit)
               elapsed[k] = 1'b0;
            r.slot = it.timer_id;
            owed_results.push_back(r);
         end
         FUNC_SET_PERIOD: begin
            if (hit)
               timer_period[k] = it.period;
            r.slot = it.timer_id;
            owed_results.push_back(r);
         end
         FUNC_STATUS: begin
            r.slot = it.timer_id;
            if (hit) begin
               r.elapsed_flag = elapsed[k];
               r.active_flag  = running[k];
            end
            owed_results.push_back(r);
         end
         default: begin
            r.ms_count = ms_total;
            owed_results.push_back(r);
         end
      endcase
   endtask

   task automatic check_result(input rsp_item_type got);
      rsp_item_type want;
      if (owed_results.size() == 0) begin
         flag_mismatch("result with nothing due, slot", 32'(got.slot), 32'd0);
      end else begin
         want = owed_results.pop_front();
         compare_field("slot", 32'(got.slot), 32'(want.slot));
         compare_field("fired_callback", 32'(got.fired_callback), 32'(want.fired_callback));
         compare_field("fired_event", 32'(got.fired_event), 32'(want.fired_event));
         compare_field("event_out", 32'(got.event_out), 32'(want.event_out));
         compare_field("elapsed_flag", 32'(got.elapsed_flag), 32'(want.elapsed_flag));
         compare_field("active_flag", 32'(got.active_flag), 32'(want.active_flag));
         compare_field("status", 32'(got.status), 32'(want.status));
         compare_field("ms_count", got.ms_count, want.ms_count);
         compare_field("last", 32'(got.last), 32'(want.last));
      end
   endtask

   // Check results before predicting, so an item's own results queue behind older ones
   always @(posedge clock) begin
      if (reset) begin
         clear_bank();
         owed_results.delete();
      end else begin
         if (rsp_strobe)
            check_result(rsp_item);
         if (start && !busy)
            predict_item(req_item);
      end
      results_due <= owed_results.size();
   end

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
   import mcstb_pkg::*;

   localparam int NUM_TIMERS   = 8;
   localparam int RANDOM_ITEMS = 400;
   localparam int DRAIN_CYCLES = NUM_TIMERS + 8;

   logic         clock    = 1'b0;
   logic         reset    = 1'b1;
   logic         start    = 1'b0;
   req_item_type req_item = '0;
   logic         busy;
   logic         rsp_strobe;
   rsp_item_type rsp_item;
   int           error_count;
   int           results_due;
   int           steady_left = 0;

   always #4 clock = ~clock;

   multi_channel_soft_timer_bank #(
      .NUM_TIMERS(NUM_TIMERS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item)
   );

   timer_bank_checker #(
      .NUM_TIMERS(NUM_TIMERS)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item),
      .error_count(error_count),
      .results_due(results_due)
   );

   // Gap before the next item; now and then a stretch with no gaps at all
   function automatic int draw_gap();
      if (steady_left > 0) begin
         steady_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0)
         steady_left = $urandom_range(10, 30);
      return $urandom_range(0, 6);
   endfunction

   function automatic req_item_type make_item(input logic [2:0] func,
                                              input logic [2:0] id,
                                              input logic [15:0] period,
                                              input logic rep,
                                              input logic [1:0] mode,
                                              input logic [7:0] code);
      req_item_type it;
      it.func       = func;
      it.timer_id   = id;
      it.period     = period;
      it.repeating  = rep;
      it.mode       = mode;
      it.event_code = code;
      return it;
   endfunction

   // Mostly short periods so timers fire often; some zero, some anywhere
   function automatic logic [15:0] draw_period();
      case ($urandom_range(0, 9))
         0:       return 16'd0;
         1, 2:    return 16'($urandom);
         default: return 16'($urandom_range(1, 10));
      endcase
   endfunction

   // Tick-heavy mix with random content in every field
   function automatic req_item_type draw_item();
      req_item_type it;
      int           pick;
      it.timer_id   = 3'($urandom_range(0, 7));
      it.period     = 16'($urandom);
      it.repeating  = 1'($urandom_range(0, 1));
      it.mode       = 2'($urandom_range(0, 3));
      it.event_code = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         it.func = FUNC_TICK;
      end else if (pick < 57) begin
         it.func = FUNC_START;
      end else if (pick < 65) begin
         it.func = FUNC_CANCEL;
      end else if (pick < 71) begin
         it.func = FUNC_CLEAR;
      end else if (pick < 81) begin
         it.func   = FUNC_SET_PERIOD;
         it.period = draw_period();
      end else if (pick < 89) begin
         it.func = FUNC_STATUS;
      end else if (pick < 94) begin
         it.func = FUNC_READ_MS;
      end else begin
         it.func   = FUNC_DECLARE;
         it.period = draw_period();
      end
      return it;
   endfunction

   // Present one item after a random gap and hold it until the block takes it
   task automatic send_item(input req_item_type it);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
   endtask

   // Hold off until the checker has nothing left due
   task automatic wait_drained();
      @(posedge clock);
      while (results_due != 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Ticks before any start are ignored; undeclared slots answer with zeros
      send_item(make_item(FUNC_TICK, 3'd0, 16'd0, 1'b0, MODE_CALLBACK, 8'd0));
      send_item(make_item(FUNC_READ_MS, 3'd0, 16'd0, 1'b0, MODE_CALLBACK, 8'd0));
      send_item(make_item(FUNC_STATUS, 3'd7, 16'd0, 1'b0, MODE_CALLBACK, 8'd0));
      send_item(make_item(FUNC_CANCEL, 3'd5, 16'd0, 1'b0, MODE_CALLBACK, 8'd0));
      // Declare one timer of each mode
      send_item(make_item(FUNC_DECLARE, 3'd0, 16'd1, 1'b1, MODE_CALLBACK, 8'hFF));
      send_item(make_item(FUNC_DECLARE, 3'd7, 16'd2, 1'b0, MODE_EVENT, 8'hA5));
      send_item(make_item(FUNC_DECLARE, 3'd0, 16'd3, 1'b1, MODE_DUAL, 8'h5A));
      send_item(make_item(FUNC_DECLARE, 3'd0, 16'd1, 1'b0, MODE_ELAPSED, 8'h00));
      for (int i = 0; i < 4; i++)
         send_item(make_item(FUNC_START, 3'(i), 16'd0, 1'b0, MODE_CALLBACK, 8'd0));
      repeat (3)
         send_item(make_item(FUNC_TICK, 3'd0, 16'd0, 1'b0, MODE_CALLBACK, 8'd0));
      // Elapsed mark of the one-shot, then clear it
      send_item(make_item(FUNC_STATUS, 3'd3, 16'd0, 1'b0, MODE_CALLBACK, 8'd0));
      send_item(make_item(FUNC_CLEAR, 3'd3, 16'd0, 1'b0, MODE_CALLBACK, 8'd0));
      send_item(make_item(FUNC_STATUS, 3'd3, 16'd0, 1'b0, MODE_CALLBACK, 8'd0));
      // Period zero, maximum period, restart of a fired one-shot, start while active
      send_item(make_item(FUNC_DECLARE, 3'd0, 16'd0, 1'b1, MODE_DUAL, 8'hFF));
      send_item(make_item(FUNC_DECLARE, 3'd0, 16'hFFFF, 1'b0, MODE_EVENT, 8'h81));
      send_item(make_item(FUNC_SET_PERIOD, 3'd1, 16'd4, 1'b0, MODE_CALLBACK, 8'd0));
      send_item(make_item(FUNC_START, 3'd1, 16'd0, 1'b0, MODE_CALLBACK, 8'd0));
      send_item(make_item(FUNC_START, 3'd0, 16'd0, 1'b0, MODE_CALLBACK, 8'd0));
      // Fill the table, then overflow it
      send_item(make_item(FUNC_DECLARE, 3'd0, 16'd2, 1'b1, MODE_EVENT, 8'h3C));
      send_item(make_item(FUNC_DECLARE, 3'd0, 16'd5, 1'b1, MODE_ELAPSED, 8'hC3));
      send_item(make_item(FUNC_DECLARE, 3'd0, 16'd7, 1'b1, MODE_CALLBACK, 8'h11));
      send_item(make_item(FUNC_READ_MS, 3'd0, 16'd0, 1'b0, MODE_CALLBACK, 8'd0));

      // Random mix, with one full drain halfway through
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) begin
            start <= 1'b0;
            wait_drained();
         end
         send_item(draw_item());
      end

      // Drain and give the verdict
      start <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && results_due == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Give up if the run hangs
   initial begin
      #1_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
